// ----- hdl/edfs_pkg.sv -----
// Shared types and constants of the deadline scheduler.
`default_nettype none
package edfs_pkg;
	localparam int MaxTasksDef = 16;
	localparam int TaskIdW = 4;

	localparam logic [2:0] OP_CFG = 3'd0;
	localparam logic [2:0] OP_ENQ = 3'd1;
	localparam logic [2:0] OP_DEQ = 3'd2;
	localparam logic [2:0] OP_UPD = 3'd3;
	localparam logic [2:0] OP_EVT = 3'd4;

	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_RUN  = 2'd1;
	localparam logic [1:0] MODE_NEXT = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  task_id;
		logic [63:0] now;
		logic [63:0] start_time;
		logic [31:0] irq_time;
		logic [30:0] run_len;
		logic [31:0] rel_deadline;
		logic [31:0] period_len;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         head_task;
		logic               head_valid;
		logic               error;
		logic               waiting;
		logic [63:0]        wake_time;
		logic               resched;
		logic               missed;
		logic [63:0]        event_time;
		logic signed [31:0] slice_left;
	} out_item_t;
endpackage
`default_nettype wire

// ----- hdl/edfs_in_if.sv -----
// Request channel of the deadline scheduler.
`default_nettype none
interface edfs_in_if;
	logic               valid;
	logic               ready;
	edfs_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/edfs_out_if.sv -----
// Result channel of the deadline scheduler.
`default_nettype none
interface edfs_out_if;
	logic                valid;
	logic                ready;
	edfs_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/edfs_rem.sv -----
// Bit-serial remainder unit: 64-bit dividend modulo 32-bit divisor.
`default_nettype none
module edfs_rem (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      rem
);
	logic [63:0] num_q;
	logic [32:0] rem_q;
	logic [31:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], num_q[63]};
	assign diff    = shifted - {1'b0, div_q};
	assign rem     = rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q <= {num_q[62:0], 1'b0};
				rem_q <= diff[32] ? shifted : diff;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/edf_task_scheduler_unit.sv -----
// Top level of the periodic earliest-deadline-first task scheduler.
// One request beat at a time; the request side is not ready until the result is taken.
// A period catch-up runs through the remainder unit, and a ready-list insert or removal walks
// one list entry per cycle, then shifts the list.
// Reset clears the task table, the ready flags and the ready count asynchronously.
`default_nettype none
module edf_task_scheduler_unit #(
	parameter int MAX_TASKS = edfs_pkg::MaxTasksDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	edfs_in_if.sink    in_ch,
	edfs_out_if.source out_ch
);
	import edfs_pkg::*;

	localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CntW = $clog2(MAX_TASKS + 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EXEC  = 9'b000000010,
		ST_CATCH = 9'b000000100,
		ST_DIV   = 9'b000001000,
		ST_FIN   = 9'b000010000,
		ST_SLC   = 9'b000100000,
		ST_SCAN  = 9'b001000000,
		ST_SHIFT = 9'b010000000,
		ST_RESP  = 9'b100000000
	} state_t;

	state_t state_q;
	in_item_t req_q;

	logic [1:0]         mode_q   [MAX_TASKS];
	logic [63:0]        fin_q    [MAX_TASKS];
	logic signed [31:0] slice_q  [MAX_TASKS];
	logic [30:0]        budget_q [MAX_TASKS];
	logic [31:0]        dl_q     [MAX_TASKS];
	logic [31:0]        per_q    [MAX_TASKS];
	logic [MAX_TASKS-1:0] rdy_q;
	logic [TaskIdW-1:0] order_q  [MAX_TASKS];
	logic [63:0]        key_q    [MAX_TASKS];
	logic [CntW-1:0]    count_q;

	logic [CntW-1:0] idx_q;
	logic            ins_q;
	logic [63:0]     f_q;
	logic [63:0]     newkey_q;
	logic [63:0]     u_q;
	logic            err_q, wait_q, rs_q, miss_q;
	logic [63:0]     wake_q, ev_q;

	logic            div_start_q;
	logic            div_done;
	logic [31:0]     div_rem;
	logic [63:0]     div_x_q;

	logic [IdxW-1:0] ix;
	logic [IdxW-1:0] sx;
	logic            tid_ok;
	logic [63:0]     d64;
	logic [63:0]     p64;
	logic signed [64:0] diff65;
	logic signed [31:0] r_sat;
	logic [63:0]     endt;
	logic            miss_now;

	assign ix     = IdxW'(req_q.task_id);
	assign sx     = idx_q[IdxW-1:0];
	assign tid_ok = (32'(req_q.task_id) < MAX_TASKS);
	assign d64    = 64'(dl_q[ix]);
	assign p64    = 64'(per_q[ix]);
	assign diff65 = 65'(slice_q[ix]) - $signed({u_q[63], u_q});
	assign endt   = req_q.start_time + 64'(slice_q[ix]);
	assign miss_now = fin_q[ix] <= req_q.now;

	always_comb begin
		if (diff65 < -65'sd2147483648)
			r_sat = 32'sh80000000;
		else if (diff65 > 65'sd2147483647)
			r_sat = 32'sh7fffffff;
		else
			r_sat = diff65[31:0];
	end

	edfs_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_x_q),
		.divisor  (per_q[ix]),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_RESP);
	assign out_ch.data.head_task  = (count_q != '0) ? order_q[0] : '0;
	assign out_ch.data.head_valid = (count_q != '0);
	assign out_ch.data.error      = err_q;
	assign out_ch.data.waiting    = wait_q;
	assign out_ch.data.wake_time  = wake_q;
	assign out_ch.data.resched    = rs_q;
	assign out_ch.data.missed     = miss_q;
	assign out_ch.data.event_time = ev_q;
	assign out_ch.data.slice_left = tid_ok ? slice_q[ix] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rdy_q       <= '0;
			div_start_q <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++) begin
				mode_q[i]   <= MODE_INIT;
				fin_q[i]    <= '0;
				slice_q[i]  <= '0;
				budget_q[i] <= '0;
				dl_q[i]     <= '0;
				per_q[i]    <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						req_q   <= in_ch.data;
						err_q   <= 1'b0;
						wait_q  <= 1'b0;
						wake_q  <= '0;
						rs_q    <= 1'b0;
						miss_q  <= 1'b0;
						ev_q    <= '0;
						idx_q   <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
					if (!tid_ok) begin
						err_q <= 1'b0 | 1'b1;
					end else begin
						case (req_q.op)
							OP_CFG: begin
								if ({1'b0, req_q.run_len} > req_q.rel_deadline ||
										req_q.period_len == '0) begin
									err_q <= 1'b1;
								end else begin
									budget_q[ix] <= req_q.run_len;
									dl_q[ix]     <= req_q.rel_deadline;
									per_q[ix]    <= req_q.period_len;
									mode_q[ix]   <= MODE_INIT;
									fin_q[ix]    <= '0;
									slice_q[ix]  <= '0;
									if (rdy_q[ix]) begin
										ins_q   <= 1'b0;
										state_q <= ST_SCAN;
									end
								end
							end
							OP_ENQ: begin
								if (rdy_q[ix]) begin
									err_q <= 1'b1;
								end else if (slice_q[ix] > 0) begin
									newkey_q <= fin_q[ix];
									ins_q    <= 1'b1;
									state_q  <= ST_SCAN;
								end else begin
									if (mode_q[ix] == MODE_INIT)
										f_q <= req_q.now;
									else if (mode_q[ix] == MODE_NEXT)
										f_q <= fin_q[ix];
									else
										f_q <= fin_q[ix] - d64 + p64;
									state_q <= ST_CATCH;
								end
							end
							OP_DEQ: begin
								if (rdy_q[ix]) begin
									ins_q   <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							OP_UPD: begin
								if (slice_q[ix] > 0) begin
									u_q     <= req_q.now - req_q.start_time -
										64'(req_q.irq_time);
									state_q <= ST_SLC;
								end
							end
							OP_EVT: begin
								ev_q <= (endt > fin_q[ix]) ? fin_q[ix] : endt;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CATCH: begin
					if (f_q <= req_q.now && (req_q.now - f_q) >= d64 && p64 != '0) begin
						div_x_q     <= req_q.now - f_q - d64;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						f_q     <= req_q.now - d64 + p64 - 64'(div_rem);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (f_q > req_q.now) begin
						fin_q[ix]  <= f_q;
						mode_q[ix] <= MODE_NEXT;
						wait_q     <= 1'b1;
						wake_q     <= f_q;
						state_q    <= ST_RESP;
					end else begin
						fin_q[ix]   <= f_q + d64;
						newkey_q    <= f_q + d64;
						slice_q[ix] <= $signed({1'b0, budget_q[ix]});
						mode_q[ix]  <= MODE_RUN;
						ins_q       <= 1'b1;
						state_q     <= ST_SCAN;
					end
				end
				ST_SLC: begin
					if (miss_now || r_sat <= 0)
						rs_q <= 1'b1;
					miss_q      <= miss_now;
					slice_q[ix] <= miss_now ? '0 : r_sat;
					state_q     <= ST_RESP;
				end
				ST_SCAN: begin
					if (ins_q) begin
						if (idx_q == count_q || key_q[sx] > newkey_q)
							state_q <= ST_SHIFT;
						else
							idx_q <= idx_q + 1'b1;
					end else begin
						if (order_q[sx] == req_q.task_id)
							state_q <= ST_SHIFT;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				ST_SHIFT: begin
					if (ins_q) begin
						for (int i = 1; i < MAX_TASKS; i++) begin
							if (i > 32'(idx_q)) begin
								order_q[i] <= order_q[i-1];
								key_q[i]   <= key_q[i-1];
							end
						end
						order_q[sx] <= req_q.task_id;
						key_q[sx]   <= newkey_q;
						count_q     <= count_q + 1'b1;
						rdy_q[ix]   <= 1'b1;
					end else begin
						for (int i = 0; i < MAX_TASKS - 1; i++) begin
							if (i >= 32'(idx_q)) begin
								order_q[i] <= order_q[i+1];
								key_q[i]   <= key_q[i+1];
							end
						end
						count_q   <= count_q - 1'b1;
						rdy_q[ix] <= 1'b0;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_ch.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_TASKS) else $error("ready count out of range");
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(rdy_q)) == 32'(count_q)) else $error("ready flags and count differ");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("request taken while result pending");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("remainder finished outside catch-up");
`endif
endmodule
`default_nettype wire
